// ===== sv/srfs_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the SAM record field splitter.
// Used by the front, queue, back and top-level modules; depends on nothing.
package srfs_pkg;

	localparam int FIELD_LIMIT = 11;
	localparam int MASK_FIELDS = 11;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

	// Result kinds.
	localparam logic [2:0] KIND_STR = 3'd0;
	localparam logic [2:0] KIND_INT = 3'd1;
	localparam logic [2:0] KIND_END = 3'd2;
	localparam logic [2:0] KIND_HDR = 3'd3;
	localparam logic [2:0] KIND_ERR = 3'd4;

	// Characters the parser looks for.
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_AT    = 8'h40;

	localparam logic [MASK_FIELDS-1:0] MASK_RESET = 11'd410;

	// One queue entry holds everything a single text byte produces. The only
	// byte with two results is an LF closing an integer field: the integer
	// value followed by the record end.
	typedef struct packed {
		logic [2:0]         kind0;
		logic [3:0]         field0;
		logic signed [31:0] value0;
		logic               two;
		logic [3:0]         field1;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// ===== sv/srfs_front.sv =====
`timescale 1ns / 1ps
// Front part of the splitter: accepts text bytes, tracks line and field
// state, parses integer fields and pushes result entries. Uses srfs_pkg.
module srfs_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [7:0]                      text_byte,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [srfs_pkg::MASK_FIELDS-1:0] integer_field_mask,
	input  srfs_pkg::q_stat_t               q_stat,
	output logic                            push,
	output srfs_pkg::entry_t                push_entry
);
	import srfs_pkg::*;

	localparam logic [1:0] MODE_REC  = 2'd0;
	localparam logic [1:0] MODE_HDR  = 2'd1;
	localparam logic [1:0] MODE_SKIP = 2'd2;

	localparam logic [1:0] PH_BLANK = 2'd0;
	localparam logic [1:0] PH_SIGN  = 2'd1;
	localparam logic [1:0] PH_DIGIT = 2'd2;
	localparam logic [1:0] PH_STOP  = 2'd3;

	localparam logic [3:0]  LIMIT4  = 4'(FIELD_LIMIT);
	localparam logic [35:0] SAT_MAG = 36'h080000000;

	logic [MASK_FIELDS-1:0] mask_q;
	logic [3:0]  field_q, field_n;
	logic        start_q, start_n;
	logic [1:0]  mode_q, mode_n;
	logic        seen_q, seen_n;
	logic [31:0] acc_q, acc_n;
	logic        neg_q, neg_n;
	logic [1:0]  phase_q, phase_n;

	logic        accept;
	logic [15:0] mask_ext;
	logic [3:0]  f_e;
	logic [31:0] acc_e;
	logic        neg_e;
	logic [1:0]  phase_e;
	logic        is_int;
	logic        is_digit;
	logic        is_blank;
	logic [35:0] acc36;
	logic [35:0] times_ten;
	logic [31:0] num_val;

	assign in_stall  = q_stat.full;
	assign cfg_ready = 1'b1;
	assign accept    = in_valid && !q_stat.full;
	assign mask_ext  = {{(16 - MASK_FIELDS){1'b0}}, mask_q};

	assign is_digit = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);
	assign is_blank = (text_byte == CH_SPACE) || (text_byte == CH_VT) ||
		(text_byte == CH_FF);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q  <= MASK_RESET;
			field_q <= '0;
			start_q <= 1'b1;
			mode_q  <= MODE_REC;
			seen_q  <= 1'b0;
			acc_q   <= '0;
			neg_q   <= 1'b0;
			phase_q <= PH_BLANK;
		end else begin
			if (cfg_valid) begin
				mask_q <= integer_field_mask;
			end
			field_q <= field_n;
			start_q <= start_n;
			mode_q  <= mode_n;
			seen_q  <= seen_n;
			acc_q   <= acc_n;
			neg_q   <= neg_n;
			phase_q <= phase_n;
		end
	end

	// A record line's first byte restarts field and number state before it
	// is handled, so the handling below works on these effective values.
	always_comb begin
		f_e     = start_q ? 4'd0 : field_q;
		acc_e   = start_q ? 32'd0 : acc_q;
		neg_e   = start_q ? 1'b0 : neg_q;
		phase_e = start_q ? PH_BLANK : phase_q;
		is_int  = (f_e < LIMIT4) && (f_e < 4'(MASK_FIELDS)) && mask_ext[f_e];
		num_val = neg_e ? (32'd0 - acc_e) : (acc_e[31] ? 32'h7FFFFFFF : acc_e);
		acc36     = {4'd0, acc_e};
		times_ten = (acc36 << 3) + (acc36 << 1) + {32'd0, text_byte[3:0]};
	end

	always_comb begin
		field_n = field_q;
		start_n = start_q;
		mode_n  = mode_q;
		seen_n  = seen_q;
		acc_n   = acc_q;
		neg_n   = neg_q;
		phase_n = phase_q;
		push    = 1'b0;
		push_entry.kind0  = KIND_STR;
		push_entry.field0 = f_e;
		push_entry.value0 = {24'd0, text_byte};
		push_entry.two    = 1'b0;
		push_entry.field1 = '0;

		if (accept && (text_byte != CH_CR)) begin
			if (start_q && (text_byte == CH_AT)) begin
				start_n = 1'b0;
				push    = 1'b1;
				push_entry.field0 = '0;
				if (!seen_q) begin
					mode_n = MODE_HDR;
					push_entry.kind0 = KIND_HDR;
				end else begin
					mode_n = MODE_SKIP;
					push_entry.kind0  = KIND_ERR;
					push_entry.value0 = '0;
				end
			end else if (!start_q && (mode_q == MODE_HDR)) begin
				start_n = (text_byte == CH_LF);
				push    = 1'b1;
				push_entry.kind0  = KIND_HDR;
				push_entry.field0 = '0;
			end else if (!start_q && (mode_q == MODE_SKIP)) begin
				start_n = (text_byte == CH_LF);
			end else begin
				start_n = 1'b0;
				mode_n  = MODE_REC;
				seen_n  = 1'b1;
				field_n = f_e;
				acc_n   = acc_e;
				neg_n   = neg_e;
				phase_n = phase_e;
				if (text_byte == CH_LF) begin
					push = 1'b1;
					if (is_int) begin
						push_entry.kind0  = KIND_INT;
						push_entry.value0 = num_val;
						push_entry.two    = 1'b1;
					end else begin
						push_entry.kind0  = KIND_END;
						push_entry.value0 = '0;
					end
					push_entry.field1 = (f_e < LIMIT4) ? (f_e + 4'd1) : LIMIT4;
					if (!is_int) begin
						push_entry.field0 = push_entry.field1;
					end
					field_n = '0;
					acc_n   = '0;
					neg_n   = 1'b0;
					phase_n = PH_BLANK;
					start_n = 1'b1;
				end else if (f_e >= LIMIT4) begin
					// Optional tags are dropped up to the end of the line.
				end else if (text_byte == CH_TAB) begin
					if (is_int) begin
						push = 1'b1;
						push_entry.kind0  = KIND_INT;
						push_entry.value0 = num_val;
					end
					field_n = f_e + 4'd1;
					acc_n   = '0;
					neg_n   = 1'b0;
					phase_n = PH_BLANK;
				end else if (is_int) begin
					if ((phase_e == PH_BLANK) && is_blank) begin
						// Leading blanks are skipped.
					end else if ((phase_e == PH_BLANK) &&
						((text_byte == CH_PLUS) || (text_byte == CH_MINUS))) begin
						neg_n   = (text_byte == CH_MINUS);
						phase_n = PH_SIGN;
					end else if (phase_e == PH_STOP) begin
						// Number already ended at a non-digit.
					end else if (!is_digit) begin
						phase_n = PH_STOP;
					end else begin
						phase_n = PH_DIGIT;
						acc_n   = (times_ten > SAT_MAG) ? SAT_MAG[31:0] : times_ten[31:0];
					end
				end else begin
					push = 1'b1;
				end
			end
		end
	end

endmodule

// ===== sv/srfs_queue.sv =====
`timescale 1ns / 1ps
// Short queue of result entries between the front and the back part.
// Uses srfs_pkg for the entry type and depth.
module srfs_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  srfs_pkg::entry_t   push_entry,
	input  logic               pop,
	output srfs_pkg::entry_t   head,
	output srfs_pkg::q_stat_t  q_stat
);
	import srfs_pkg::*;

	entry_t                 entries_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_PTR_W:0]   count_q;

	assign head         = entries_q[rd_ptr_q];
	assign q_stat.full  = (count_q == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
	assign q_stat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== sv/srfs_back.sv =====
`timescale 1ns / 1ps
// Back part of the splitter: takes queue entries and delivers their results
// one per cycle while out_stall is low, via an output register. Uses srfs_pkg.
module srfs_back (
	input  logic               clk,
	input  logic               arst_n,
	input  srfs_pkg::entry_t   head,
	input  srfs_pkg::q_stat_t  q_stat,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         kind,
	output logic [3:0]         field_number,
	output logic signed [31:0] value,
	output logic               last
);
	import srfs_pkg::*;

	logic              valid_q;
	logic [2:0]        kind_q;
	logic [3:0]        field_q;
	logic signed [31:0] value_q;
	logic              last_q;
	logic              second_q;
	logic              load;

	assign out_valid    = valid_q;
	assign kind         = kind_q;
	assign field_number = field_q;
	assign value        = value_q;
	assign last         = last_q;

	assign load = !valid_q || !out_stall;
	// A two-result entry stays at the head until its record end goes out.
	assign pop  = load && !q_stat.empty && (!head.two || second_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			second_q <= 1'b0;
		end else if (load) begin
			valid_q <= !q_stat.empty;
			if (!q_stat.empty) begin
				second_q <= head.two && !second_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && !q_stat.empty) begin
			if (head.two && second_q) begin
				kind_q  <= KIND_END;
				field_q <= head.field1;
				value_q <= '0;
				last_q  <= 1'b1;
			end else begin
				kind_q  <= head.kind0;
				field_q <= head.field0;
				value_q <= head.value0;
				last_q  <= !head.two;
			end
		end
	end

endmodule

// ===== sv/sam_record_field_splitter_top.sv =====
`timescale 1ns / 1ps
// Top level of the SAM record field splitter: front, result queue and back.
// Uses srfs_pkg and the srfs_front, srfs_queue and srfs_back modules.
//
// The block takes one text byte per cycle while in_stall is low, classifying
// it in the same cycle; a byte's results enter a four-entry queue and leave
// through a registered output one per cycle while out_stall is low. Every
// byte gives zero, one or two results (two only for an LF that closes an
// integer field), so the sustained rate is one byte per cycle except that
// such an LF holds the output for both results. With the queue empty and the
// output free, a byte's first result goes via a queue entry to the output
// register. in_stall rises only when the queue is full. The integer field
// mask may be written whenever the block is idle; cfg_ready is always high.
module sam_record_field_splitter_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [7:0]                       text_byte,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [srfs_pkg::MASK_FIELDS-1:0] integer_field_mask,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [2:0]                       kind,
	output logic [3:0]                       field_number,
	output logic signed [31:0]               value,
	output logic                             last
);
	import srfs_pkg::*;

	q_stat_t q_stat;
	entry_t  push_entry;
	entry_t  head;
	logic    push;
	logic    pop;

	srfs_front u_front (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.text_byte          (text_byte),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.integer_field_mask (integer_field_mask),
		.q_stat             (q_stat),
		.push               (push),
		.push_entry         (push_entry)
	);

	srfs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.q_stat     (q_stat)
	);

	srfs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_stat       (q_stat),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.field_number (field_number),
		.value        (value),
		.last         (last)
	);

	// Only the integer value before a record end is ever not the last result.
	a_not_last_is_int: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> kind == KIND_INT)
		else $error("non-last result is not an integer value");

	// A delivered first half must be followed at once by its record end.
	a_end_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last && !out_stall |=> out_valid && kind == KIND_END && last)
		else $error("record end did not follow integer value");

	a_header_field_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_HDR || kind == KIND_ERR) |-> field_number == 4'd0)
		else $error("header or error result with nonzero field");

	// The queue must never be pushed while full or popped while empty.
	a_queue_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && q_stat.full) && !(pop && q_stat.empty))
		else $error("queue overflow or underflow");

endmodule
